/* hw/rtl/ecal_pkg.sv */
package ecal_pkg;

   // Calendar constants.
   localparam int unsigned EPOCH_YEAR      = 1970;
   localparam int unsigned SECS_PER_DAY    = 86400;
   localparam int unsigned SECS_PER_HOUR   = 3600;
   localparam int unsigned SECS_PER_MINUTE = 60;
   localparam int unsigned DAYS_PER_CYCLE  = 146097;
   localparam int unsigned YEARS_PER_CYCLE = 400;

   // Epoch year taken modulo 4, 100 and 400, and the weekday of the epoch (Thursday).
   localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
   localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
   localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);
   localparam logic [2:0] EPOCH_WDAY   = 3'd4;

   localparam int unsigned PC_BITS  = 4;
   localparam int unsigned CNT_BITS = 6;

   typedef enum logic [3:0] {
      OP_DIV_DAY,
      OP_CYCLE,
      OP_YEAR,
      OP_MONTH,
      OP_SET_CNT,
      OP_HOUR,
      OP_MINUTE,
      OP_WEEK,
      OP_DONE
   } op_type;

   typedef enum logic [1:0] {
      JC_NEXT,
      JC_CNT,
      JC_TOOK
   } jump_type;

   // Program addresses.
   localparam logic [PC_BITS-1:0] STEP_DIV      = 4'd0;
   localparam logic [PC_BITS-1:0] STEP_CYCLE    = 4'd1;
   localparam logic [PC_BITS-1:0] STEP_YEAR     = 4'd2;
   localparam logic [PC_BITS-1:0] STEP_MONTH    = 4'd3;
   localparam logic [PC_BITS-1:0] STEP_SET_HOUR = 4'd4;
   localparam logic [PC_BITS-1:0] STEP_HOUR     = 4'd5;
   localparam logic [PC_BITS-1:0] STEP_SET_MIN  = 4'd6;
   localparam logic [PC_BITS-1:0] STEP_MINUTE   = 4'd7;
   localparam logic [PC_BITS-1:0] STEP_WEEK     = 4'd8;
   localparam logic [PC_BITS-1:0] STEP_DONE     = 4'd9;

   typedef struct packed {
      op_type               op;
      jump_type             jump;
      logic [PC_BITS-1:0]   target;
      logic [2:0]           imm;
   } ctrl_type;

   typedef struct packed {
      ctrl_type             word;
      logic [CNT_BITS-1:0]  cnt;
      logic                 fire;
   } seq_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  week_day;
   } result_type;

   // The microprogram.
   function automatic ctrl_type rom_word(input logic [PC_BITS-1:0] pc);
      ctrl_type w;
      begin
         unique case (pc)
            STEP_DIV:      w = '{op: OP_DIV_DAY, jump: JC_CNT,  target: STEP_DIV,    imm: 3'd0};
            STEP_CYCLE:    w = '{op: OP_CYCLE,   jump: JC_TOOK, target: STEP_CYCLE,  imm: 3'd0};
            STEP_YEAR:     w = '{op: OP_YEAR,    jump: JC_TOOK, target: STEP_YEAR,   imm: 3'd0};
            STEP_MONTH:    w = '{op: OP_MONTH,   jump: JC_TOOK, target: STEP_MONTH,  imm: 3'd0};
            STEP_SET_HOUR: w = '{op: OP_SET_CNT, jump: JC_NEXT, target: STEP_DIV,    imm: 3'd4};
            STEP_HOUR:     w = '{op: OP_HOUR,    jump: JC_CNT,  target: STEP_HOUR,   imm: 3'd0};
            STEP_SET_MIN:  w = '{op: OP_SET_CNT, jump: JC_NEXT, target: STEP_DIV,    imm: 3'd5};
            STEP_MINUTE:   w = '{op: OP_MINUTE,  jump: JC_CNT,  target: STEP_MINUTE, imm: 3'd0};
            STEP_WEEK:     w = '{op: OP_WEEK,    jump: JC_NEXT, target: STEP_DIV,    imm: 3'd0};
            default:       w = '{op: OP_DONE,    jump: JC_NEXT, target: STEP_DIV,    imm: 3'd0};
         endcase
         return w;
      end
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      begin
         case (m)
            4'd1:                      len = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
            default:                   len = 5'd31;
         endcase
         return len;
      end
   endfunction

   // Reduces a value below 42 modulo 7.
   function automatic logic [2:0] mod7(input logic [5:0] v);
      logic [5:0] r;
      begin
         r = v;
         for (int i = 0; i < 5; i++) begin
            if (r >= 6'd7) begin
               r = r - 6'd7;
            end
         end
         return r[2:0];
      end
   endfunction

endpackage

/* hw/rtl/ecal_seq.sv */
module ecal_seq #(
   parameter int unsigned STAMP_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                stall,
   input  logic                took,
   output ecal_pkg::seq_type   seq,
   output logic                busy,
   output logic                done
);

   logic [ecal_pkg::PC_BITS-1:0]  pc_ff, pc_in;
   logic [ecal_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   ecal_pkg::ctrl_type            word;
   logic                          fire;

   assign word = ecal_pkg::rom_word(pc_ff);
   // The final step waits while the output register still holds an untaken result.
   assign fire = busy_ff && !((word.op == ecal_pkg::OP_DONE) && stall);

   assign seq.word = word;
   assign seq.cnt  = cnt_ff;
   assign seq.fire = fire;
   assign busy     = busy_ff;
   assign done     = fire && (word.op == ecal_pkg::OP_DONE);

   always_comb begin
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         pc_in   = ecal_pkg::STEP_DIV;
         cnt_in  = ecal_pkg::CNT_BITS'(STAMP_BITS - 1);
         busy_in = 1'b1;
      end else if (fire) begin
         pc_in = pc_ff + 4'd1;
         unique case (word.jump)
            ecal_pkg::JC_CNT: begin
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - 1'b1;
                  pc_in  = word.target;
               end
            end
            ecal_pkg::JC_TOOK: begin
               if (took) begin
                  pc_in = word.target;
               end
            end
            default: begin
            end
         endcase
         if (word.op == ecal_pkg::OP_SET_CNT) begin
            cnt_in = ecal_pkg::CNT_BITS'(word.imm);
         end
         if (word.op == ecal_pkg::OP_DONE) begin
            busy_in = 1'b0;
            pc_in   = ecal_pkg::STEP_DIV;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= ecal_pkg::STEP_DIV;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

endmodule

/* hw/rtl/ecal_dp.sv */
module ecal_dp #(
   parameter int unsigned STAMP_BITS = 32
) (
   input  logic                   clock,
   input  logic                   start,
   input  logic [STAMP_BITS-1:0]  stamp,
   input  ecal_pkg::seq_type      seq,
   output logic                   took,
   output ecal_pkg::result_type   result
);

   // num holds the stamp, then the day count; part holds the time of day remainder.
   logic [STAMP_BITS-1:0] num_ff, num_in;
   logic [16:0]           part_ff, part_in;
   logic [11:0]           year_ff, year_in;
   logic [1:0]            y4_ff, y4_in;
   logic [6:0]            y100_ff, y100_in;
   logic [8:0]            y400_ff, y400_in;
   logic [3:0]            month_ff, month_in;
   logic [4:0]            hour_ff, hour_in;
   logic [5:0]            minute_ff, minute_in;
   logic [2:0]            wd_ff, wd_in;

   logic        leap;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [17:0] div_part;
   logic        div_ge;
   logic [16:0] hour_step;
   logic [16:0] minute_step;
   logic [5:0]  week_sum;

   always_comb begin
      num_in    = num_ff;
      part_in   = part_ff;
      year_in   = year_ff;
      y4_in     = y4_ff;
      y100_in   = y100_ff;
      y400_in   = y400_ff;
      month_in  = month_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      wd_in     = wd_ff;
      took      = 1'b0;

      leap        = ((y4_ff == 2'd0) && (y100_ff != 7'd0)) || (y400_ff == 9'd0);
      ylen        = leap ? 9'd366 : 9'd365;
      mlen        = ecal_pkg::month_len(month_ff, leap);
      div_part    = {part_ff, num_ff[STAMP_BITS-1]};
      div_ge      = div_part >= 18'(ecal_pkg::SECS_PER_DAY);
      hour_step   = 17'(ecal_pkg::SECS_PER_HOUR) << seq.cnt[2:0];
      minute_step = 17'(ecal_pkg::SECS_PER_MINUTE) << seq.cnt[2:0];
      week_sum    = 6'(wd_ff) + 6'(num_ff[4:0]);

      if (start) begin
         num_in    = stamp;
         part_in   = '0;
         year_in   = 12'(ecal_pkg::EPOCH_YEAR);
         y4_in     = ecal_pkg::EPOCH_MOD4;
         y100_in   = ecal_pkg::EPOCH_MOD100;
         y400_in   = ecal_pkg::EPOCH_MOD400;
         month_in  = '0;
         hour_in   = '0;
         minute_in = '0;
         wd_in     = ecal_pkg::EPOCH_WDAY;
      end else if (seq.fire) begin
         unique case (seq.word.op)
            ecal_pkg::OP_DIV_DAY: begin
               part_in = div_ge ? 17'(div_part - 18'(ecal_pkg::SECS_PER_DAY)) : div_part[16:0];
               num_in  = {num_ff[STAMP_BITS-2:0], div_ge};
            end
            ecal_pkg::OP_CYCLE: begin
               // A 400-year cycle is a whole number of weeks and keeps the leap pattern.
               if (num_ff >= STAMP_BITS'(ecal_pkg::DAYS_PER_CYCLE)) begin
                  took    = 1'b1;
                  num_in  = num_ff - STAMP_BITS'(ecal_pkg::DAYS_PER_CYCLE);
                  year_in = year_ff + 12'(ecal_pkg::YEARS_PER_CYCLE);
               end
            end
            ecal_pkg::OP_YEAR: begin
               if (num_ff >= STAMP_BITS'(ylen)) begin
                  took    = 1'b1;
                  num_in  = num_ff - STAMP_BITS'(ylen);
                  year_in = year_ff + 12'd1;
                  y4_in   = y4_ff + 2'd1;
                  y100_in = (y100_ff == 7'd99) ? 7'd0 : y100_ff + 7'd1;
                  y400_in = (y400_ff == 9'd399) ? 9'd0 : y400_ff + 9'd1;
                  wd_in   = ecal_pkg::mod7(6'(wd_ff) + (leap ? 6'd2 : 6'd1));
               end
            end
            ecal_pkg::OP_MONTH: begin
               if ((month_ff < 4'd12) && (num_ff >= STAMP_BITS'(mlen))) begin
                  took     = 1'b1;
                  num_in   = num_ff - STAMP_BITS'(mlen);
                  month_in = month_ff + 4'd1;
                  wd_in    = ecal_pkg::mod7(6'(wd_ff) + 6'(mlen - 5'd28));
               end
            end
            ecal_pkg::OP_HOUR: begin
               if (part_ff >= hour_step) begin
                  part_in                 = part_ff - hour_step;
                  hour_in[seq.cnt[2:0]]   = 1'b1;
               end
            end
            ecal_pkg::OP_MINUTE: begin
               if (part_ff >= minute_step) begin
                  part_in                 = part_ff - minute_step;
                  minute_in[seq.cnt[2:0]] = 1'b1;
               end
            end
            ecal_pkg::OP_WEEK: begin
               wd_in = ecal_pkg::mod7(week_sum);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      part_ff   <= part_in;
      year_ff   <= year_in;
      y4_ff     <= y4_in;
      y100_ff   <= y100_in;
      y400_ff   <= y400_in;
      month_ff  <= month_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      wd_ff     <= wd_in;
   end

   assign result.year     = year_ff;
   assign result.month    = month_ff + 4'd1;
   assign result.day      = num_ff[4:0] + 5'd1;
   assign result.hour     = hour_ff;
   assign result.minute   = minute_ff;
   assign result.second   = part_ff[5:0];
   assign result.week_day = wd_ff;

endmodule

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Converts an unsigned count of seconds since 1970-01-01 00:00:00 UTC into the Gregorian
// date, the time of day and the weekday (0 is Sunday). One request is worked on at a
// time by a small microcoded sequencer: a ten-step program in a read-only table drives a
// datapath with a compare-and-subtract unit for each of its loops. The program divides
// the stamp bit by bit by the seconds in a day, then takes whole 400-year cycles, years
// and months off the day count, and then splits the remainder of the day into hours,
// minutes and seconds. The year loop removes one year per cycle. A new request is
// accepted as soon as the previous one has left the sequencer, even while its result
// still waits in the output register. Years wrap to their low 12 bits when wider stamps
// run past 4095.
module epoch_seconds_to_calendar #(
   parameter int unsigned STAMP_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel. tdata: epoch_seconds, zero-filled to whole bytes.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((STAMP_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // Response channel. tdata from bit 0: cal_year[11:0], cal_month[15:12],
   // cal_day[20:16], cal_hour[25:21], cal_minute[31:26], cal_second[37:32],
   // week_day[40:38], zero fill [47:41].
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [47:0]                           rsp_tdata
);

   ecal_pkg::seq_type    seq;
   ecal_pkg::result_type result;
   logic                 start;
   logic                 stall;
   logic                 took;
   logic                 busy;
   logic                 done;

   logic                 rsp_tvalid_ff;
   logic [47:0]          rsp_data_ff;
   logic [47:0]          rsp_data_in;

   // A request is taken whenever the sequencer is free.
   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;

   // The final program step holds while the output register is full and not being read.
   assign stall = rsp_tvalid_ff && !rsp_tready;

   ecal_seq #(
      .STAMP_BITS (STAMP_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stall (stall),
      .took  (took),
      .seq   (seq),
      .busy  (busy),
      .done  (done)
   );

   ecal_dp #(
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock  (clock),
      .start  (start),
      .stamp  (req_tdata[STAMP_BITS-1:0]),
      .seq    (seq),
      .took   (took),
      .result (result)
   );

   assign rsp_data_in = {7'd0, result.week_day, result.second, result.minute,
                         result.hour, result.day, result.month, result.year};

   // Output register separating the sequencer from the response channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (done) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   // A result never appears in the cycle right after a request is accepted.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !$rose(rsp_tvalid))
      else $error("response appeared one cycle after request acceptance");

   // A held result is never overwritten by a newer one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("pending response was overwritten");

   // The month of a valid result is always 1 through 12.
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[15:12] != 4'd0) && (rsp_tdata[15:12] <= 4'd12)))
      else $error("month out of range");

   // The weekday of a valid result is always 0 through 6.
   a_wday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[40:38] != 3'd7))
      else $error("weekday out of range");
`endif

endmodule
